// File: hw/rtl/mcp_pkg.sv
// Package for the memory region carve planner.
// Holds the transaction structs, state codes and constants; no dependencies.
package mcp_pkg;

  localparam int MAX_DESCRIPTORS_DEF = 32;
  localparam logic [63:0] ONE_MIB = 64'h0000_0000_0010_0000;
  localparam int PAGE_SHIFT = 12;

  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic REG_USABLE_LIMIT = 1'b0;
  localparam logic REG_CONV_TYPE = 1'b1;

  localparam logic OP_LOAD = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  desc_type;
    logic [63:0] desc_start;
    logic [51:0] desc_pages;
    logic [51:0] want_pages;
    logic        consecutive_only;
  } cmd_t;

  typedef struct packed {
    logic [63:0] region_start;
    logic [51:0] region_pages;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [63:0] start;
    logic [51:0] pages;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_CHECK, S_LD_CLIP, S_SO_RDI, S_SO_GETI, S_SO_SCAN,
    S_SO_SW1, S_SO_SW2, S_CA_RD, S_CA_EV, S_CA_SHORT
  } state_t;

endpackage

// File: hw/rtl/mcp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module mcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/memory_region_carve_planner.sv
// Top level of the memory region carve planner.
// Depends on mcp_pkg and on the table RAM mcp_ram.
//
// A load transaction (opcode 0) filters one memory descriptor and, if it is
// kept, appends the adjusted region to the table; busy stays high through the
// check and clip states after acceptance, so a new load is not taken until the
// last one is through. A plan transaction (opcode 1) sorts the table largest
// first with a selection sort that reads one table entry per cycle while it
// scans, through the single read port of the table RAM, spends a state priming
// the read, and then walks the sorted table at one entry per cycle, emitting at
// most one result per cycle, plus a shortfall transaction when pages are still
// missing. Results appear on result for exactly one cycle while result_valid is
// high; the receiver cannot stall them, so it must take every strobe. A plan
// with no pages requested answers with a single status result and no sort.
// Every plan empties the table.
module memory_region_carve_planner
  import mcp_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mcp_pkg::cmd_t  cmd,
  output logic           result_valid,
  output mcp_pkg::result_t result,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [63:0]    cfg_data
);

  localparam int IW = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int CW = $clog2(MAX_DESCRIPTORS + 1);

  state_t state, state_next;

  logic [63:0] usable_limit;
  logic [7:0]  conv_type;

  cmd_t        item;
  logic [51:0] need;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  entry_t      ent_i;
  entry_t      best;
  logic [IW-1:0] best_idx;
  logic [63:0] ld_start;
  logic [51:0] ld_pages;
  logic        ld_drop;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  // Load check: exact 65-bit end address, then the raise to 1 MiB.
  logic [64:0] ld_end;
  logic [20:0] below_mib;
  logic [51:0] below_pages;
  logic        chk_drop;
  always_comb begin
    ld_end = {1'b0, item.desc_start} + {1'b0, item.desc_pages, 12'h000};
    below_mib = 21'(ONE_MIB - item.desc_start);
    below_pages = 52'(below_mib[20:PAGE_SHIFT]) + 52'(below_mib[11:0] != 12'h000);
    chk_drop = (item.desc_type != conv_type) || (item.desc_start > usable_limit) ||
               (ld_end <= {1'b0, ONE_MIB}) || (item.desc_pages == 52'd0);
  end

  // Load clip: the region must end at or below the last usable page.
  logic [51:0] top_page;
  logic [52:0] first_page;
  logic [53:0] end_page;
  logic [51:0] clip_pages;
  logic        keep;
  always_comb begin
    top_page = usable_limit[63:PAGE_SHIFT];
    first_page = 53'(ld_start[63:PAGE_SHIFT]) + 53'(ld_start[11:0] != 12'h000);
    end_page = 54'(first_page) + 54'(ld_pages);
    clip_pages = ld_pages;
    if (end_page > 54'(top_page)) begin
      clip_pages = (first_page >= 53'(top_page)) ? 52'd0
                                                 : 52'(53'(top_page) - first_page);
    end
    keep = !ld_drop && (clip_pages != 52'd0) && (count < CW'(MAX_DESCRIPTORS));
  end

  // Carve step on the entry just read from the table.
  logic        skip;
  logic [51:0] grant;
  logic [63:0] grant_start;
  logic [51:0] need_new;
  always_comb begin
    skip = (rd_data.pages < need) && item.consecutive_only;
    grant = rd_data.pages;
    grant_start = rd_data.start;
    if (rd_data.pages > need) begin
      grant = need;
      grant_start = rd_data.start + {rd_data.pages - need, 12'h000};
    end
    need_new = need - grant;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_LOAD) begin
            state_next = S_LD_CHECK;
          end else if (cmd.want_pages == 52'd0) begin
            state_next = S_IDLE;
          end else if (count == '0) begin
            state_next = S_CA_SHORT;
          end else begin
            state_next = S_SO_RDI;
          end
        end
      end
      S_LD_CHECK: state_next = S_LD_CLIP;
      S_LD_CLIP:  state_next = S_IDLE;
      S_SO_RDI:   state_next = S_SO_GETI;
      S_SO_GETI:  state_next = (j < count) ? S_SO_SCAN : S_SO_SW1;
      S_SO_SCAN:  state_next = ((j + 1'b1) < count) ? S_SO_SCAN : S_SO_SW1;
      S_SO_SW1:   state_next = S_SO_SW2;
      S_SO_SW2:   state_next = ((i + 1'b1) < count) ? S_SO_RDI : S_CA_RD;
      S_CA_RD:    state_next = S_CA_EV;
      S_CA_EV: begin
        if (!skip && need_new == 52'd0) begin
          state_next = S_IDLE;
        end else if ((i + 1'b1) < count) begin
          state_next = S_CA_EV;
        end else begin
          state_next = S_CA_SHORT;
        end
      end
      S_CA_SHORT: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Table RAM controls.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = '{start: ld_start, pages: clip_pages};
    rd_addr = i[IW-1:0];
    unique case (state)
      S_LD_CLIP: wr_en = keep;
      S_SO_GETI: rd_addr = j[IW-1:0];
      S_SO_SCAN: rd_addr = IW'(j + 1'b1);
      S_SO_SW1: begin
        wr_en = 1'b1;
        wr_addr = i[IW-1:0];
        wr_data = best;
      end
      S_SO_SW2: begin
        wr_en = 1'b1;
        wr_addr = best_idx;
        wr_data = ent_i;
      end
      S_CA_EV: rd_addr = IW'(i + 1'b1);
      default: rd_addr = i[IW-1:0];
    endcase
  end

  mcp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_DESCRIPTORS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      usable_limit <= 64'h0000_0000_FFFF_FFFF;
      conv_type <= 8'd7;
      count <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_USABLE_LIMIT: usable_limit <= cfg_data;
          REG_CONV_TYPE:    conv_type <= cfg_data[7:0];
          default:          usable_limit <= usable_limit;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.opcode != OP_LOAD && cmd.want_pages == 52'd0) begin
            // Nothing requested: a single status transaction, table emptied.
            result_valid <= 1'b1;
            result <= '{region_start: 64'd0, region_pages: 52'd0,
                        status: ST_NONE, last: 1'b1};
            count <= '0;
          end
        end
        S_LD_CLIP: begin
          if (keep) begin
            count <= count + 1'b1;
          end
        end
        S_CA_EV: begin
          if (!skip) begin
            result_valid <= 1'b1;
            result <= '{region_start: grant_start, region_pages: grant,
                        status: ST_GRANT, last: (need_new == 52'd0)};
            if (need_new == 52'd0) begin
              count <= '0;
            end
          end
        end
        S_CA_SHORT: begin
          result_valid <= 1'b1;
          result <= '{region_start: 64'd0, region_pages: need,
                      status: ST_SHORT, last: 1'b1};
          count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item <= cmd;
          need <= cmd.want_pages;
          i <= '0;
        end
      end
      S_LD_CHECK: begin
        ld_drop <= chk_drop;
        ld_start <= item.desc_start;
        ld_pages <= item.desc_pages;
        if (item.desc_start < ONE_MIB) begin
          ld_start <= ONE_MIB;
          ld_pages <= item.desc_pages - below_pages;
        end
      end
      S_SO_RDI: j <= i + 1'b1;
      S_SO_GETI: begin
        ent_i <= rd_data;
        best <= rd_data;
        best_idx <= i[IW-1:0];
      end
      S_SO_SCAN: begin
        if (best.pages < rd_data.pages) begin
          best <= rd_data;
          best_idx <= j[IW-1:0];
        end
        j <= j + 1'b1;
      end
      S_SO_SW2: i <= ((i + 1'b1) < count) ? CW'(i + 1'b1) : '0;
      S_CA_EV: begin
        if (!skip) begin
          need <= need_new;
        end
        i <= i + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: dv/tb_memory_region_carve_planner.sv
// Self-checking testbench for the memory region carve planner.
// Depends on mcp_pkg and the memory_region_carve_planner RTL; a scoreboard class predicts results.
module tb_memory_region_carve_planner;
  import mcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PLAN = ~OP_LOAD;
  localparam int TABLE_DEPTH = MAX_DESCRIPTORS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [51:0] MASK52 = {52{1'b1}};

  // The scoreboard keeps its own copy of the region table and of the two
  // registers. Every accepted command is folded into that copy, and plan
  // commands queue the grants and status items the block must emit.
  class carve_scoreboard;
    logic [63:0] usable_limit;
    logic [7:0]  conv_type;
    logic [63:0] region_base [TABLE_DEPTH];
    logic [51:0] region_size [TABLE_DEPTH];
    int          region_count;
    result_t     pending_grants[$];
    int          errors;

    function new();
      usable_limit = 64'h0000_0000_FFFF_FFFF;
      conv_type = 8'd7;
      region_count = 0;
      errors = 0;
    endfunction

    function logic [63:0] pages_up(logic [63:0] bytes);
      return (bytes >> PAGE_SHIFT) + ((bytes[11:0] != 12'd0) ? 64'd1 : 64'd0);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_command(cmd_t c);
      logic [63:0] st, fin, pgw, top, first, base, tb;
      logic [51:0] need, sz, ts;
      int i, j, best;
      result_t r;
      if (c.opcode == OP_LOAD) begin
        st = c.desc_start;
        pgw = {12'd0, c.desc_pages};
        fin = st + (pgw << PAGE_SHIFT);
        if (c.desc_type != conv_type || st > usable_limit) return;
        // The end is exact: a sum that wraps past 64 bits lies above 1 MiB.
        if (!(fin < st) && fin <= ONE_MIB) return;
        if (pgw == 64'd0) return;
        if (st < ONE_MIB) begin
          pgw -= pages_up(ONE_MIB - st);
          st = ONE_MIB;
        end
        top = usable_limit >> PAGE_SHIFT;
        first = pages_up(st);
        if (first + pgw > top) pgw = (first >= top) ? 64'd0 : top - first;
        if (pgw == 64'd0 || region_count >= TABLE_DEPTH) return;
        region_base[region_count] = st;
        region_size[region_count] = pgw[51:0];
        region_count++;
        return;
      end
      need = c.want_pages;
      if (need == 52'd0) begin
        r = '{region_start: 64'd0, region_pages: 52'd0, status: ST_NONE, last: 1'b1};
        pending_grants.push_back(r);
        region_count = 0;
        return;
      end
      // Selection sort, largest first; ties keep the earlier entry in place.
      for (i = 0; i < region_count; i++) begin
        best = i;
        for (j = i + 1; j < region_count; j++)
          if (region_size[best] < region_size[j]) best = j;
        if (best != i) begin
          tb = region_base[i]; ts = region_size[i];
          region_base[i] = region_base[best]; region_size[i] = region_size[best];
          region_base[best] = tb; region_size[best] = ts;
        end
      end
      // Carve from the top end of each region in sorted order.
      for (i = 0; i < region_count; i++) begin
        base = region_base[i];
        sz = region_size[i];
        if (sz < need && c.consecutive_only) continue;
        if (sz > need) begin
          base += {12'd0, sz - need} << PAGE_SHIFT;
          sz = need;
        end
        need -= sz;
        r = '{region_start: base, region_pages: sz, status: ST_GRANT, last: need == 52'd0};
        pending_grants.push_back(r);
        if (need == 52'd0) break;
      end
      if (need != 52'd0) begin
        r = '{region_start: 64'd0, region_pages: need, status: ST_SHORT, last: 1'b1};
        pending_grants.push_back(r);
      end
      region_count = 0;
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending_grants.size() == 0) begin
        report($sformatf("unexpected result start=%h pages=%h status=%0d",
                         got.region_start, got.region_pages, got.status));
        return;
      end
      want = pending_grants.pop_front();
      if (got.region_start !== want.region_start)
        report($sformatf("region_start %h, expected %h", got.region_start, want.region_start));
      if (got.region_pages !== want.region_pages)
        report($sformatf("region_pages %h, expected %h", got.region_pages, want.region_pages));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_USABLE_LIMIT;
  logic [63:0] cfg_data = '0;

  carve_scoreboard sb = new();
  int cycles = 0;
  int items = 0;

  memory_region_carve_planner u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Results cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    cycles++;
    if (!rst && result_valid) sb.check_result(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Most gaps are zero or short, a few are long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one transaction; start stays high across back-to-back transactions.
  task send(cmd_t c);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    items++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Lets every expected result arrive, then the tail of any load still in flight.
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_grants.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_reg(logic idx, logic [63:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_USABLE_LIMIT) sb.usable_limit = data;
    else sb.conv_type = data[7:0];
  endtask

  function cmd_t load_cmd(logic [7:0] t, logic [63:0] s, logic [51:0] p);
    cmd_t c;
    c = '0;
    c.opcode = OP_LOAD;
    c.desc_type = t;
    c.desc_start = s;
    c.desc_pages = p;
    c.want_pages = 52'({$urandom, $urandom});
    c.consecutive_only = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function cmd_t plan_cmd(logic [51:0] need, logic consec);
    cmd_t c;
    c = '0;
    c.opcode = OP_PLAN;
    c.desc_type = 8'($urandom);
    c.desc_start = {$urandom, $urandom};
    c.desc_pages = 52'({$urandom, $urandom});
    c.want_pages = need;
    c.consecutive_only = consec;
    return c;
  endfunction

  // A descriptor that usually survives the filter: conventional type and a
  // page-aligned start within a window of random size, up to 2^34 bytes.
  function cmd_t random_load();
    logic [7:0]  t;
    logic [63:0] s;
    logic [51:0] p;
    int r;
    t = ($urandom_range(0, 99) < 85) ? sb.conv_type : 8'($urandom);
    r = $urandom_range(0, 9);
    if (r < 2) s = 64'($urandom_range(0, 300)) << PAGE_SHIFT;
    else if (r < 9) s = {$urandom, $urandom} & ((64'd1 << $urandom_range(20, 34)) - 64'd1);
    else s = {$urandom, $urandom};
    if (r < 9) s[11:0] = 12'd0;
    p = ($urandom_range(0, 9) < 8) ? 52'($urandom_range(0, 3000)) : 52'({$urandom, $urandom});
    return load_cmd(t, s, p);
  endfunction

  function cmd_t random_plan();
    int r;
    logic [51:0] need;
    r = $urandom_range(0, 19);
    if (r == 0) need = 52'd0;
    else if (r < 17) need = 52'($urandom_range(1, 6000));
    else need = 52'({$urandom, $urandom});
    return plan_cmd(need, 1'($urandom_range(0, 1)));
  endfunction

  // Well-formed bursts of loads closed by a plan, with a little noise mixed in.
  task random_phase(int count);
    int n, k;
    logic [191:0] noise;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 36);
      if (k > count - n - 1) k = count - n - 1;
      repeat (k) begin
        if ($urandom_range(0, 19) == 0) begin
          noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          send(cmd_t'(noise[$bits(cmd_t)-1:0]));
        end else begin
          send(random_load());
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
      send(random_plan());
      n += k + 1;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    send(load_cmd(8'd7, 64'd0, 52'd300));                    // starts below 1 MiB
    send(load_cmd(8'd7, 64'd0, 52'd256));                    // ends exactly at 1 MiB
    send(load_cmd(8'd7, 64'h0000_0000_0020_0000, 52'd0));    // empty descriptor
    send(load_cmd(8'd6, 64'h0000_0000_0030_0000, 52'd40));   // wrong type
    send(load_cmd(8'd7, {64{1'b1}}, MASK52));                // start past the limit
    send(load_cmd(8'd7, 64'h0000_0000_FFFF_E000, 52'd10));   // clipped at the limit
    send(load_cmd(8'd7, 64'h0000_0000_1000_0000, MASK52));   // huge, clipped
    send(load_cmd(8'd7, 64'h0000_0000_0040_0000, 52'd64));
    send(load_cmd(8'd7, 64'h0000_0000_0050_0000, 52'd64));   // tie in size
    send(plan_cmd(52'd100, 1'b1));
    send(plan_cmd(52'd5, 1'b0));                             // empty table
    send(load_cmd(8'd7, 64'h0000_0000_0060_0000, 52'd20));
    send(plan_cmd(52'd0, 1'b0));                             // nothing requested
    send(plan_cmd(52'd1, 1'b0));                             // table emptied
    send(cmd_t'({$bits(cmd_t){1'b1}}));                      // all ones: plan, shortfall
    send(cmd_t'('0));                                         // all zeros: ignored load
    drain();

    write_reg(REG_USABLE_LIMIT, {64{1'b1}});
    write_reg(REG_CONV_TYPE, 64'd255);
    send(load_cmd(8'd255, 64'hFFFF_FFFF_FFFF_F000, MASK52)); // end wraps past 64 bits
    send(load_cmd(8'd255, 64'h0000_0000_000F_F000, 52'd2));
    send(load_cmd(8'd255, 64'h8000_0000_0000_0000, MASK52));
    send(plan_cmd(MASK52, 1'b0));
    random_phase(90);
    drain();

    write_reg(REG_USABLE_LIMIT, 64'd0);
    write_reg(REG_CONV_TYPE, 64'd0);
    random_phase(20);
    drain();

    write_reg(REG_USABLE_LIMIT, 64'h0000_0000_0040_0FFF);
    write_reg(REG_CONV_TYPE, 64'd7);
    random_phase(90);
    drain();

    write_reg(REG_USABLE_LIMIT, 64'h0000_0000_FFFF_FFFF);
    random_phase(90);
    drain();

    write_reg(REG_USABLE_LIMIT, {$urandom, $urandom});
    write_reg(REG_CONV_TYPE, 64'($urandom));
    random_phase(70);
    drain();
    repeat (40) @(negedge clk);

    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
